FILE: design/hsvrgb_pkg.sv
// Shared constants and types for the HSV to RGB converter.
// No dependencies; imported by hsvrgb_sector and hsv_to_rgb_converter.
`default_nettype none

package hsvrgb_pkg;

  localparam int HUE_W   = 15;
  localparam int CHAN_W  = 17;
  localparam int SEC_W   = 4;
  localparam int REM_W   = 12;
  localparam int FRAC_W  = 16;

  // 1.0 in Q1.16, and 60 degrees in 1/64-degree units
  localparam logic [CHAN_W-1:0] ONE_Q16      = CHAN_W'(65536);
  localparam logic [HUE_W-1:0]  SECTOR_UNITS = HUE_W'(3840);

  // highest sector a 15-bit hue can reach (32767 / 3840)
  localparam int MAX_SECTOR = ((1 << HUE_W) - 1) / 3840;

  // f = floor(rem * 256 / 15) = (rem * ceil(2^24 / 15)) >> 16, exact for rem < 3840
  localparam int RECIP_W = 21;
  localparam logic [RECIP_W-1:0] FRAC_RECIP = RECIP_W'((1 << 24) / 15 + 1);

  typedef struct packed {
    logic [SEC_W-1:0] sector;
    logic [REM_W-1:0] rem;
  } hue_split_t;

  // clamp a Q1.16 channel to 1.0
  function automatic logic [CHAN_W-1:0] sat_one(input logic [CHAN_W-1:0] x);
    sat_one = (x > ONE_Q16) ? ONE_Q16 : x;
  endfunction

endpackage

`default_nettype wire

FILE: design/hsvrgb_sector.sv
// Splits a hue into its 60-degree sector and the remainder within it.
// Depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_sector
  import hsvrgb_pkg::*;
(
  input  wire logic [HUE_W-1:0] hue,
  output hue_split_t            split
);

  logic [SEC_W-1:0] sec;
  logic [HUE_W-1:0] base;
  logic [HUE_W-1:0] diff;

  // thermometer of threshold compares, counted up
  always_comb begin
    sec = '0;
    for (int k = 1; k <= MAX_SECTOR; k++) begin
      if (hue >= HUE_W'(k * 3840)) begin
        sec = sec + SEC_W'(1);
      end
    end
  end

  assign base  = HUE_W'({{(HUE_W-SEC_W){1'b0}}, sec} * SECTOR_UNITS);
  assign diff  = hue - base;

  assign split.sector = sec;
  assign split.rem    = diff[REM_W-1:0];

endmodule

`default_nettype wire

FILE: design/hsv_to_rgb_converter.sv
// HSV to RGB colour converter, four-stage pipeline, Q1.16 channels.
// Depends on hsvrgb_pkg and hsvrgb_sector.
//
//  port group   dir  flow control         payload
//  -----------  ---  -------------------  ---------------------------------------
//  in_*         in   start / busy         in_hue, in_saturation, in_brightness
//  out_*        out  out_valid strobe     out_red, out_green, out_blue
//
// A word is taken on every clock edge with start high and busy low; busy
// rises only while rst_n is held low, so the block takes a word every cycle.
// Each result comes out of the last stage register as a one-cycle
// strobe; the pipeline never waits, since the receiver cannot stall it.
// The multiplier stages are reciprocal and p, then s*f products, then v
// products with the final channel select.
// Synchronous reset clears the valid bits only; payload registers float.
`default_nettype none

module hsv_to_rgb_converter
  import hsvrgb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [HUE_W-1:0]  in_hue,
  input  wire logic [CHAN_W-1:0] in_saturation,
  input  wire logic [CHAN_W-1:0] in_brightness,
  output logic                   out_valid,
  output logic [CHAN_W-1:0]      out_red,
  output logic [CHAN_W-1:0]      out_green,
  output logic [CHAN_W-1:0]      out_blue
);

  // sector codes for the channel mapping; anything above sector four
  // takes the sector-five mapping
  localparam logic [SEC_W-1:0] SEC_RED_YEL  = SEC_W'(0);
  localparam logic [SEC_W-1:0] SEC_YEL_GRN  = SEC_W'(1);
  localparam logic [SEC_W-1:0] SEC_GRN_CYN  = SEC_W'(2);
  localparam logic [SEC_W-1:0] SEC_CYN_BLU  = SEC_W'(3);
  localparam logic [SEC_W-1:0] SEC_BLU_MAG  = SEC_W'(4);

  localparam int PROD_W = 2 * CHAN_W;

  logic take;
  assign busy = ~rst_n;
  assign take = start & ~busy;

  // ---------------- stage 1: clamp, sector split ----------------
  hue_split_t split;

  hsvrgb_sector u_sector (
    .hue   (in_hue),
    .split (split)
  );

  logic               vld1_r;
  logic [CHAN_W-1:0]  sat1_r, val1_r;
  logic [SEC_W-1:0]   sec1_r;
  logic [REM_W-1:0]   rem1_r;

  always_ff @(posedge clk) begin
    sat1_r <= sat_one(in_saturation);
    val1_r <= sat_one(in_brightness);
    sec1_r <= split.sector;
    rem1_r <= split.rem;
  end

  // ---------------- stage 2: fraction, p ----------------
  logic [REM_W+RECIP_W-1:0] frac_prod;
  logic [PROD_W-1:0]        p_prod;

  assign frac_prod = {{RECIP_W{1'b0}}, rem1_r} * {{REM_W{1'b0}}, FRAC_RECIP};
  assign p_prod    = {{CHAN_W{1'b0}}, val1_r} * {{CHAN_W{1'b0}}, ONE_Q16 - sat1_r};

  logic               vld2_r;
  logic [CHAN_W-1:0]  sat2_r, val2_r, p2_r;
  logic [SEC_W-1:0]   sec2_r;
  logic [FRAC_W-1:0]  frac2_r;

  always_ff @(posedge clk) begin
    sat2_r  <= sat1_r;
    val2_r  <= val1_r;
    sec2_r  <= sec1_r;
    frac2_r <= frac_prod[FRAC_W+15:16];
    p2_r    <= p_prod[CHAN_W+15:16];
  end

  // ---------------- stage 3: s*f and s*(1-f) ----------------
  logic [PROD_W-1:0] sf_prod, sg_prod;
  logic [CHAN_W-1:0] one_minus_f;

  assign one_minus_f = ONE_Q16 - {1'b0, frac2_r};
  assign sf_prod = {{CHAN_W{1'b0}}, sat2_r} * {{(CHAN_W+1){1'b0}}, frac2_r};
  assign sg_prod = {{CHAN_W{1'b0}}, sat2_r} * {{CHAN_W{1'b0}}, one_minus_f};

  logic               vld3_r;
  logic [CHAN_W-1:0]  val3_r, p3_r, qm3_r, tm3_r;
  logic [SEC_W-1:0]   sec3_r;

  always_ff @(posedge clk) begin
    val3_r <= val2_r;
    p3_r   <= p2_r;
    sec3_r <= sec2_r;
    qm3_r  <= ONE_Q16 - sf_prod[CHAN_W+15:16];
    tm3_r  <= ONE_Q16 - sg_prod[CHAN_W+15:16];
  end

  // ---------------- stage 4: q, t, channel select ----------------
  logic [PROD_W-1:0] q_prod, t_prod;
  logic [CHAN_W-1:0] q_val, t_val;
  logic [CHAN_W-1:0] red_nxt, green_nxt, blue_nxt;

  assign q_prod = {{CHAN_W{1'b0}}, val3_r} * {{CHAN_W{1'b0}}, qm3_r};
  assign t_prod = {{CHAN_W{1'b0}}, val3_r} * {{CHAN_W{1'b0}}, tm3_r};
  assign q_val  = q_prod[CHAN_W+15:16];
  assign t_val  = t_prod[CHAN_W+15:16];

  // zero saturation needs no special arm: p = q = t = v then
  always_comb begin
    unique case (sec3_r)
      SEC_RED_YEL: begin red_nxt = val3_r; green_nxt = t_val;  blue_nxt = p3_r;   end
      SEC_YEL_GRN: begin red_nxt = q_val;  green_nxt = val3_r; blue_nxt = p3_r;   end
      SEC_GRN_CYN: begin red_nxt = p3_r;   green_nxt = val3_r; blue_nxt = t_val;  end
      SEC_CYN_BLU: begin red_nxt = p3_r;   green_nxt = q_val;  blue_nxt = val3_r; end
      SEC_BLU_MAG: begin red_nxt = t_val;  green_nxt = p3_r;   blue_nxt = val3_r; end
      default:     begin red_nxt = val3_r; green_nxt = p3_r;   blue_nxt = q_val;  end
    endcase
  end

  logic out_vld_r;
  logic [CHAN_W-1:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  // valid bits travel alongside the payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r    <= 1'b0;
      vld2_r    <= 1'b0;
      vld3_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      vld1_r    <= take;
      vld2_r    <= vld1_r;
      vld3_r    <= vld2_r;
      out_vld_r <= vld3_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  // ---------------- checks ----------------
  // every word taken comes out of the pipeline as a valid result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##4 out_valid)
    else $error("word lost in pipeline");

  // one channel always carries the value
  a_value_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red == $past(val3_r) || out_green == $past(val3_r) ||
                   out_blue == $past(val3_r)))
    else $error("no channel equals value");

  // channels never exceed 1.0
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red <= ONE_Q16 && out_green <= ONE_Q16 && out_blue <= ONE_Q16))
    else $error("channel above one");

  // p is the smallest term
  a_p_min: assert property (@(posedge clk) disable iff (!rst_n)
    vld3_r |-> (p3_r <= val3_r && p3_r <= q_val && p3_r <= t_val))
    else $error("p above q, t or v");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking bench for hsv_to_rgb_converter: directed corner pixels, then random
// traffic with varied sender gaps. Uses hsvrgb_pkg for widths and constants only.
`timescale 1ns / 1ps

module tb_top;
  import hsvrgb_pkg::*;

  // Colour-wheel sectors of 60 degrees; anything past magenta-red wraps to it
  localparam int HUE_RED_YELLOW    = 0;
  localparam int HUE_YELLOW_GREEN  = 1;
  localparam int HUE_GREEN_CYAN    = 2;
  localparam int HUE_CYAN_BLUE     = 3;
  localparam int HUE_BLUE_MAGENTA  = 4;
  localparam int HUE_MAGENTA_RED   = 5;

  localparam int PIPE_DEPTH        = 4;     // number of register stages in the block
  localparam int STALL_LIMIT       = 2000;  // cycles without any handshake
  localparam int FULL_TURN         = 23040; // 360 degrees in hue units

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [HUE_W-1:0]  in_hue = '0;
  logic [CHAN_W-1:0] in_saturation = '0;
  logic [CHAN_W-1:0] in_brightness = '0;
  logic              out_valid;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;

  rgb_t pending_rgb[$];       // colours owed by the block, oldest first
  int   words_sent = 0;
  int   colours_checked = 0;
  int   error_count = 0;
  int   quiet_cycles = 0;
  logic [8:0] sectors_hit = '0;

  hsv_to_rgb_converter i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Colour predictor. Inputs above 1.0 clamp to 1.0; products truncate, as the
  // fixed-point hardware does. All working values are kept wide so no product
  // of two Q1.16 numbers can wrap.
  // ---------------------------------------------------------------------------
  function automatic rgb_t hsv_colour(input logic [HUE_W-1:0]  hue,
                                      input logic [CHAN_W-1:0] sat_raw,
                                      input logic [CHAN_W-1:0] val_raw);
    logic [63:0] s, v, sector, rem, f, p, q, t, r, g, b;
    rgb_t c;
    s = (sat_raw > ONE_Q16) ? 64'(ONE_Q16) : 64'(sat_raw);
    v = (val_raw > ONE_Q16) ? 64'(ONE_Q16) : 64'(val_raw);
    if (s == 0) begin
      // grey: every channel is the brightness
      r = v;
      g = v;
      b = v;
    end else begin
      sector = hue / SECTOR_UNITS;
      rem    = hue % SECTOR_UNITS;
      f      = (rem << 16) / SECTOR_UNITS;            // Q0.16 position in sector
      p      = (v * (ONE_Q16 - s)) >> 16;
      q      = (v * (ONE_Q16 - ((s * f) >> 16))) >> 16;
      t      = (v * (ONE_Q16 - ((s * (ONE_Q16 - f)) >> 16))) >> 16;
      case (sector)
        HUE_RED_YELLOW: begin
          r = v; g = t; b = p;
        end
        HUE_YELLOW_GREEN: begin
          r = q; g = v; b = p;
        end
        HUE_GREEN_CYAN: begin
          r = p; g = v; b = t;
        end
        HUE_CYAN_BLUE: begin
          r = p; g = q; b = v;
        end
        HUE_BLUE_MAGENTA: begin
          r = t; g = p; b = v;
        end
        default: begin
          // magenta-red, and hues of a full turn or more fall here too
          r = v; g = p; b = q;
        end
      endcase
    end
    c.red   = r[CHAN_W-1:0];
    c.green = g[CHAN_W-1:0];
    c.blue  = b[CHAN_W-1:0];
    return c;
  endfunction

  task automatic check_channel(input string name, input logic [CHAN_W-1:0] want,
                               input logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor. Runs on the clock edge and sees pre-edge values, so it observes
  // exactly what the block samples. The result strobe is checked first; a word
  // taken on the same edge cannot come out before it has crossed the pipeline.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_rgb.size() == 0) begin
        $display("%0t ns: colour with none owed, got r=%0d g=%0d b=%0d",
                 $time, out_red, out_green, out_blue);
        error_count++;
      end else begin
        want = pending_rgb.pop_front();
        check_channel("red",   want.red,   out_red);
        check_channel("green", want.green, out_green);
        check_channel("blue",  want.blue,  out_blue);
        colours_checked++;
      end
    end
    if (rst_n && start && busy === 1'b0) begin
      pending_rgb.push_back(hsv_colour(in_hue, in_saturation, in_brightness));
      sectors_hit[4'(in_hue / SECTOR_UNITS)] <= 1'b1;
      words_sent++;
    end
  end

  // Watchdog: any handshake on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no traffic for %0d cycles, %0d colours outstanding",
               $time, STALL_LIMIT, pending_rgb.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. send_pixel is entered just after a rising edge and returns on
  // the edge that took the word, leaving start high so back-to-back words need
  // no second write to start within one step.
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input logic [HUE_W-1:0]  hue,
                            input logic [CHAN_W-1:0] sat,
                            input logic [CHAN_W-1:0] val);
    start         <= 1'b1;
    in_hue        <= hue;
    in_saturation <= sat;
    in_brightness <= val;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Idle a geometric number of cycles; the payload carries junk while idle
  task automatic sender_gap(input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start         <= 1'b0;
      in_hue        <= HUE_W'($urandom);
      in_saturation <= CHAN_W'($urandom);
      in_brightness <= CHAN_W'($urandom);
      @(posedge clk);
    end
  endtask

  // Hold off until every owed colour is back. The first edge lets the monitor
  // log the last word before the queue is inspected.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (pending_rgb.size() != 0) @(posedge clk);
  endtask

  // Mostly in-range Q1.16, with zero, exactly one and raw 17-bit values mixed in
  function automatic logic [CHAN_W-1:0] rand_q16();
    case ($urandom_range(9))
      0:       return '0;
      1:       return ONE_Q16;
      2:       return CHAN_W'($urandom);
      default: return CHAN_W'($urandom_range(65536));
    endcase
  endfunction

  // Mostly one turn of the wheel; now and then anywhere in the 15-bit range
  function automatic logic [HUE_W-1:0] rand_hue();
    if ($urandom_range(7) == 0)
      return HUE_W'($urandom);
    return HUE_W'($urandom_range(FULL_TURN - 1));
  endfunction

  task automatic random_burst(input int count, input int idle_pct);
    repeat (count) begin
      sender_gap(idle_pct);
      send_pixel(rand_hue(), rand_q16(), rand_q16());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner pixels: hues on either side of several sector boundaries, the full-turn
  // wrap, grey, and over-range saturation and brightness.
  task automatic test_corner_pixels();
    send_pixel(HUE_W'(0),                ONE_Q16, ONE_Q16);   // pure red
    send_pixel(HUE_W'(SECTOR_UNITS - 1), ONE_Q16, ONE_Q16);
    send_pixel(HUE_W'(1 * 3840),         ONE_Q16, ONE_Q16);
    send_pixel(HUE_W'(2 * 3840 - 1),     CHAN_W'(40000), CHAN_W'(50000));
    send_pixel(HUE_W'(2 * 3840),         ONE_Q16, ONE_Q16);
    send_pixel(HUE_W'(3 * 3840 - 1),     CHAN_W'(1),     ONE_Q16);
    send_pixel(HUE_W'(3 * 3840),         CHAN_W'(32768), CHAN_W'(65535));
    send_pixel(HUE_W'(4 * 3840 + 1919),  ONE_Q16, CHAN_W'(12345));
    send_pixel(HUE_W'(5 * 3840),         ONE_Q16, ONE_Q16);
    send_pixel(HUE_W'(FULL_TURN - 1),    ONE_Q16, ONE_Q16);
    send_pixel(HUE_W'(FULL_TURN),        CHAN_W'(30000), CHAN_W'(60000)); // wraps past a turn
    send_pixel(HUE_W'(7 * 3840 + 100),   ONE_Q16, ONE_Q16);
    send_pixel(HUE_W'(8 * 3840),         CHAN_W'(20000), ONE_Q16);
    send_pixel('1,                       ONE_Q16, ONE_Q16);   // top of hue range
    send_pixel(HUE_W'(1234),             '0,      CHAN_W'(40000)); // grey
    send_pixel(HUE_W'(30000),            '0,      '1);        // grey, bright clamps
    send_pixel(HUE_W'(5000),             '1,      ONE_Q16);   // saturation clamps
    send_pixel(HUE_W'(9000),             CHAN_W'(65537), '1);
    send_pixel(HUE_W'(16000),            ONE_Q16, '0);        // black
    send_pixel(HUE_W'(19000),            '1,      CHAN_W'(65537));
    send_pixel(HUE_W'(1),                CHAN_W'(1),     CHAN_W'(1));
    send_pixel(HUE_W'(21845),            CHAN_W'(21845), CHAN_W'(43690));
    drain_pipeline();
  endtask

  task automatic test_back_to_back();
    random_burst(250, 0);
  endtask

  // Sender idle in most cycles, so gaps land on every pipeline stage
  task automatic test_sparse_sender();
    random_burst(200, 83);
    drain_pipeline();
  endtask

  task automatic test_light_idle();
    random_burst(180, 22);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_corner_pixels();
    test_back_to_back();
    test_sparse_sender();
    test_light_idle();

    drain_pipeline();
    repeat (2 * PIPE_DEPTH) @(posedge clk);

    $display("Sent %0d pixels (corners, back-to-back, sparse and light idling);",
             words_sent);
    $display("checked %0d colours, hue sectors hit 8..0: %b", colours_checked,
             sectors_hit);
    if (error_count == 0 && pending_rgb.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
